// ----- hw/rtl/css_pkg.sv -----
// Package for the comment span scanner: character codes, scan mode encoding
// and the saturating counter helper. No dependencies.
package css_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam int unsigned CntW  = 32;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register word indexes, taken from paddr[2]
  localparam logic REG_FIRST_LINE = 1'b0;

  localparam logic KIND_LINE  = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  typedef enum logic [4:0] {
    MODE_IDLE       = 5'b00001,
    MODE_SLASH      = 5'b00010,
    MODE_LINE       = 5'b00100,
    MODE_BLOCK      = 5'b01000,
    MODE_BLOCK_STAR = 5'b10000
  } scan_mode_e;

  typedef logic [CntW-1:0] cnt_t;

  function automatic cnt_t sat_inc(cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

// ----- hw/rtl/css_byte_if.sv -----
// Input channel of the comment span scanner: one source byte per beat.
// Depends on nothing.
interface css_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hw/rtl/css_rec_if.sv -----
// Output channel of the comment span scanner: one comment record per beat.
// Depends on nothing.
interface css_rec_if;
  logic        valid;
  logic        ready;
  logic        comment_kind;
  logic [31:0] start_line;
  logic [31:0] start_offset;
  logic [31:0] span_len;

  modport source (output valid, output comment_kind, output start_line,
                  output start_offset, output span_len, input ready);
  modport sink   (input valid, input comment_kind, input start_line,
                  input start_offset, input span_len, output ready);
endinterface

// ----- hw/rtl/comment_span_scanner_top.sv -----
// Comment span scanner: finds line and block comments in a byte stream.
// Depends on css_pkg, css_byte_if and css_rec_if.
//
// Use: source bytes enter on in_i, one per beat. Each finished comment gives
// one record on out_o: kind, line it opened on, byte index of its first
// content byte and its size. Comments still open give nothing.
// The APB port holds one register, first_line (word 0, bit 0), which sets
// the line number of the first line to 0 or 1; it only takes effect on the
// line counter before the first byte after reset.
// Timing: a byte is taken into an input register and worked on from there;
// any record is loaded into the output register as its closing byte leaves
// the input register. One byte per cycle is sustained while the output
// does not stall; the single mode/counter update per byte sets that.
// Stalls: the output register holds a record until taken. A byte that
// would emit a record while the output is still full waits in the input
// register, and in_i.ready drops until the output drains.
// Reset: asynchronous, active low; mode goes to idle, counters to zero,
// the line counter and first_line to one.
module comment_span_scanner_top
  import css_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  css_byte_if.sink         in_i,
  css_rec_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic       cfg_we;
  logic       first_line_q;
  logic       taken_q;
  logic       in_acc;

  logic       stage_valid_q, stage_valid_d;
  logic [7:0] stage_byte_q;
  logic       stage_fire;

  scan_mode_e mode_q, mode_d;
  cnt_t       line_q, line_d;
  cnt_t       index_q, index_d;
  cnt_t       open_line_q, open_line_d;
  cnt_t       open_off_q, open_off_d;
  cnt_t       count_q, count_d;
  logic       emit;
  logic       emit_kind;

  logic       out_valid_q;
  logic       out_kind_q;
  cnt_t       out_line_q, out_off_q, out_size_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_FIRST_LINE) ? {{(DataW-1){1'b0}}, first_line_q} : '0;

  assign in_acc     = in_i.valid && in_i.ready;
  assign stage_fire = stage_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !stage_valid_q || stage_fire;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_acc) begin
      stage_valid_d = 1'b1;
    end else if (stage_fire) begin
      stage_valid_d = 1'b0;
    end
  end

  // per-byte scan step
  always_comb begin
    mode_d      = mode_q;
    line_d      = line_q;
    index_d     = index_q + cnt_t'(1);
    open_line_d = open_line_q;
    open_off_d  = open_off_q;
    count_d     = count_q;
    emit        = 1'b0;
    emit_kind   = KIND_LINE;
    case (mode_q)
      MODE_SLASH: begin
        if (stage_byte_q == CH_SLASH || stage_byte_q == CH_STAR) begin
          mode_d      = (stage_byte_q == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          open_line_d = line_q;
          open_off_d  = index_q + cnt_t'(1);
          count_d     = '0;
        end else begin
          mode_d = MODE_IDLE;
          if (stage_byte_q == CH_NL) line_d = sat_inc(line_q);
        end
      end
      MODE_LINE: begin
        count_d = sat_inc(count_q);
        if (stage_byte_q == CH_NL) begin
          emit   = 1'b1;
          line_d = sat_inc(line_q);
          mode_d = MODE_IDLE;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (mode_q == MODE_BLOCK_STAR && stage_byte_q == CH_SLASH) begin
          emit      = 1'b1;
          emit_kind = KIND_BLOCK;
          mode_d    = MODE_IDLE;
        end else begin
          count_d = sat_inc(count_q);
          if (stage_byte_q == CH_NL) line_d = sat_inc(line_q);
          mode_d = (stage_byte_q == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
        end
      end
      default: begin
        if (stage_byte_q == CH_SLASH) begin
          mode_d = MODE_SLASH;
        end else begin
          mode_d = MODE_IDLE;
          if (stage_byte_q == CH_NL) line_d = sat_inc(line_q);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q  <= 1'b1;
      taken_q       <= 1'b0;
      stage_valid_q <= 1'b0;
      mode_q        <= MODE_IDLE;
      line_q        <= cnt_t'(1);
      index_q       <= '0;
      open_line_q   <= '0;
      open_off_q    <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (in_acc) taken_q <= 1'b1;
      if (cfg_we && paddr[2] == REG_FIRST_LINE) begin
        first_line_q <= pwdata[0];
        if (!taken_q) line_q <= cnt_t'(pwdata[0]);
      end
      if (stage_fire) begin
        mode_q      <= mode_d;
        line_q      <= line_d;
        index_q     <= index_d;
        open_line_q <= open_line_d;
        open_off_q  <= open_off_d;
        count_q     <= count_d;
      end
      if (stage_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) stage_byte_q <= in_i.data_byte;
    if (stage_fire && emit) begin
      out_kind_q <= emit_kind;
      out_line_q <= open_line_q;
      out_off_q  <= open_off_q;
      // a line comment's size includes its closing newline
      out_size_q <= count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.comment_kind = out_kind_q;
  assign out_o.start_line   = out_line_q;
  assign out_o.start_offset = out_off_q;
  assign out_o.span_len     = out_size_q;

endmodule

// ----- hw/rtl/css_checker.sv -----
// Port-level checks for the comment span scanner, bound to the top level.
// Depends on comment_span_scanner_top and its interface ports.
module css_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [31:0] out_line_i,
  input logic [31:0] out_off_i,
  input logic [31:0] out_size_i
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
    $stable(out_line_i) && $stable(out_off_i) && $stable(out_size_i))
    else $error("record changed while stalled");

  // a fresh record comes from a byte accepted earlier on the input
  a_rec_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("record without a matching byte");

  // every comment counts at least its newline or closing star
  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_size_i != 32'd0)
    else $error("comment of zero size");

  // input is never refused while nothing is waiting at the output
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind comment_span_scanner_top css_checker u_css_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.comment_kind),
  .out_line_i  (out_o.start_line),
  .out_off_i   (out_o.start_offset),
  .out_size_i  (out_o.span_len)
);
